// File: rtl/assert_macros.svh
// Assertion macros for the detector fault supervisor RTL.
// Included by files that carry concurrent checks; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property violated");
`define DFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define DFS_ASSERT(lbl, clk, rst_n, prop)
`define DFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/dfs_pkg.sv
// Package for the detector fault supervisor: widths, status and register
// codes, reset values and the record passed from front to back.
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;

    localparam int NUM_DETECTORS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int IDX_W      = 5;
    localparam int CNT_W      = 15;
    localparam int TIME_W     = 16;
    localparam int FLOW_W     = 12;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Quotient bits retired per cycle by the long-off divider
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = TIME_W / DIV_BITS_PER_STEP;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_LONG_OFF = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG_ON  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_ON_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF_FLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FLOW_LIMIT = 2'd3;

    localparam logic [TIME_W-1:0] LONG_ON_LIMIT_RST  = 16'd2400;
    localparam logic [TIME_W-1:0] LONG_OFF_BASE_RST  = 16'd32000;
    localparam logic [TIME_W-1:0] LONG_OFF_FLOOR_RST = 16'd1200;
    localparam logic [FLOW_W-1:0] LOW_FLOW_LIMIT_RST = 12'd15;

    typedef struct packed {
        logic [TIME_W-1:0] long_on_limit;
        logic [TIME_W-1:0] long_off_base;
        logic [TIME_W-1:0] long_off_floor;
        logic [FLOW_W-1:0] low_flow_limit;
    } dfs_cfg_t;

    // One classified check on its way to the back end
    typedef struct packed {
        logic [IDX_W-1:0]  det_index;
        logic              in_range;
        logic [STAT_W-1:0] rise_sat;
        logic              long_on;
        logic              off_check;
        logic [TIME_W-1:0] off_time;
        logic [FLOW_W-1:0] sflow;
    } dfs_rec_t;

endpackage
`default_nettype wire

// File: rtl/dfs_if.sv
// Handshake interfaces of the detector fault supervisor: check items,
// result items and configuration writes. Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dfs_item_if;
    import dfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  det_index;
    logic [CNT_W-1:0]  count_now;
    logic [CNT_W-1:0]  count_ref;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
    logic [TIME_W-1:0] cycle_time;
    logic [FLOW_W-1:0] smoothed_flow;
    logic [FLOW_W-1:0] mean_flow;
    logic              long_off_eligible;

    modport source (output valid, det_index, count_now, count_ref, on_time, off_time,
                    cycle_time, smoothed_flow, mean_flow, long_off_eligible,
                    input ready);
    modport sink (input valid, det_index, count_now, count_ref, on_time, off_time,
                  cycle_time, smoothed_flow, mean_flow, long_off_eligible,
                  output ready);
endinterface

interface dfs_result_if;
    import dfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  result_index;
    logic [STAT_W-1:0] new_status;
    logic              notify_ok;
    logic              notify_long_on;
    logic              notify_long_off;
    logic              divide_error;

    modport source (output valid, result_index, new_status, notify_ok, notify_long_on,
                    notify_long_off, divide_error, input ready);
    modport sink (input valid, result_index, new_status, notify_ok, notify_long_on,
                  notify_long_off, divide_error, output ready);
endinterface

interface dfs_cfg_if;
    import dfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/dfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dfs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/dfs_cfg.sv
// Configuration register file of the detector fault supervisor.
// Depends on dfs_pkg and dfs_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module dfs_cfg (
    input  logic             clk,
    input  logic             rst_n,
    dfs_cfg_if.sink          cfg,
    output dfs_pkg::dfs_cfg_t regs
);
    import dfs_pkg::*;

    dfs_cfg_t cfg_reg;
    dfs_cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LONG_ON_LIMIT:  cfg_next.long_on_limit  = cfg.data;
                REG_LONG_OFF_BASE:  cfg_next.long_off_base  = cfg.data;
                REG_LONG_OFF_FLOOR: cfg_next.long_off_floor = cfg.data;
                REG_LOW_FLOW_LIMIT: cfg_next.low_flow_limit = cfg.data[FLOW_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_on_limit  <= LONG_ON_LIMIT_RST;
            cfg_reg.long_off_base  <= LONG_OFF_BASE_RST;
            cfg_reg.long_off_floor <= LONG_OFF_FLOOR_RST;
            cfg_reg.low_flow_limit <= LOW_FLOW_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign regs = cfg_reg;

endmodule
`default_nettype wire

// File: rtl/dfs_front.sv
// Front end: accepts check items, classifies them (count rise, long-on,
// long-off eligibility, index range) into a record. Depends on dfs_pkg, dfs_if.
`timescale 1ns / 1ps
`default_nettype none
module dfs_front #(
    parameter int NUM_DETECTORS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    dfs_item_if.sink          item,
    input  dfs_pkg::dfs_cfg_t regs,
    output dfs_pkg::dfs_rec_t rec,
    output logic              rec_valid,
    input  logic              rec_ready
);
    import dfs_pkg::*;

    logic             stage_valid_reg;
    logic             stage_valid_next;
    dfs_rec_t         stage_rec_reg;
    dfs_rec_t         stage_rec_next;
    logic             accept;
    logic             rise_pos;
    logic [CNT_W-1:0] rise;

    assign item.ready = !stage_valid_reg || rec_ready;
    assign accept     = item.valid && item.ready;

    // A status is at most 3, so a rise saturated at 3 recovers exactly as the
    // full 15-bit rise would.
    assign rise_pos = item.count_now > item.count_ref;
    assign rise     = item.count_now - item.count_ref;

    always_comb
    begin
        stage_rec_next.det_index = item.det_index;
        stage_rec_next.in_range  = 32'(item.det_index) < NUM_DETECTORS;
        if (!rise_pos)
        begin
            stage_rec_next.rise_sat = '0;
        end
        else if (rise[CNT_W-1:STAT_W] != '0)
        begin
            stage_rec_next.rise_sat = '1;
        end
        else
        begin
            stage_rec_next.rise_sat = rise[STAT_W-1:0];
        end
        stage_rec_next.long_on   = (item.on_time >= item.cycle_time) ||
                                   (item.on_time >= regs.long_on_limit);
        stage_rec_next.off_check = (item.mean_flow > regs.low_flow_limit) &&
                                   item.long_off_eligible;
        stage_rec_next.off_time  = item.off_time;
        stage_rec_next.sflow     = item.smoothed_flow;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_rec_reg <= stage_rec_next;
        end
    end

    assign rec       = stage_rec_reg;
    assign rec_valid = stage_valid_reg;

endmodule
`default_nettype wire

// File: rtl/dfs_queue.sv
// Short queue of classified records between front and back ends.
// Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfs_queue #(
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dfs_pkg::dfs_rec_t push_rec,
    input  logic              push_valid,
    output logic              push_ready,
    output dfs_pkg::dfs_rec_t pop_rec,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import dfs_pkg::*;

    dfs_rec_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_rec    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dfs_back.sv
// Back end: long-off threshold divider, status read-modify-write and the
// result register. Depends on dfs_pkg, dfs_if, dfs_ram, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfs_back #(
    parameter int NUM_DETECTORS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dfs_pkg::dfs_cfg_t regs,
    input  dfs_pkg::dfs_rec_t rec,
    input  logic              rec_valid,
    output logic              rec_pop,
    dfs_result_if.source      result
);
    import dfs_pkg::*;

    localparam int ADDR_W = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [FLOW_W:0]          rem_reg, rem_next;
    logic [TIME_W-1:0]        quo_reg, quo_next;
    dfs_rec_t                 work_reg, work_next;
    logic [NUM_DETECTORS-1:0] valid_bits_reg, valid_bits_next;
    logic                     res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]         res_index_reg, res_index_next;
    logic [STAT_W-1:0]        res_status_reg, res_status_next;
    logic                     res_ok_reg, res_ok_next;
    logic                     res_on_reg, res_on_next;
    logic                     res_off_reg, res_off_next;
    logic                     res_derr_reg, res_derr_next;

    logic [FLOW_W:0]          div_rem;
    logic [TIME_W-1:0]        div_quo;
    logic [ADDR_W-1:0]        addr;
    logic [STAT_W-1:0]        ram_rdata;
    logic                     ram_we;
    logic [STAT_W-1:0]        stored;
    logic [STAT_W-1:0]        status;
    logic                     n_ok;
    logic                     div_err;
    logic [TIME_W-1:0]        thresh;
    logic                     finish;

    assign addr = ADDR_W'(work_reg.det_index);

    dfs_ram #(
        .WIDTH (STAT_W),
        .DEPTH (NUM_DETECTORS)
    ) u_status_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (status),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    // Restoring divide, DIV_BITS_PER_STEP quotient bits per cycle
    always_comb
    begin
        div_rem = rem_reg;
        div_quo = quo_reg;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++)
        begin
            div_rem = {div_rem[FLOW_W-1:0], div_quo[TIME_W-1]};
            div_quo = {div_quo[TIME_W-2:0], 1'b0};
            if (div_rem >= {1'b0, work_reg.sflow})
            begin
                div_rem    = div_rem - {1'b0, work_reg.sflow};
                div_quo[0] = 1'b1;
            end
        end
    end

    // Status update for the item held in work_reg
    always_comb
    begin
        stored = ST_OK;
        if (work_reg.in_range && valid_bits_reg[addr])
        begin
            stored = ram_rdata;
        end
        div_err = work_reg.sflow == '0;
        thresh  = div_err ? regs.long_off_base : quo_reg;
        if (thresh < regs.long_off_floor)
        begin
            thresh = regs.long_off_floor;
        end
        status = stored;
        n_ok   = 1'b0;
        if (stored != ST_OK && work_reg.rise_sat != '0)
        begin
            if (work_reg.rise_sat >= stored)
            begin
                status = ST_OK;
                n_ok   = 1'b1;
            end
            else
            begin
                status = stored - work_reg.rise_sat;
            end
        end
        if (work_reg.long_on)
        begin
            status = ST_LONG_ON;
        end
        if (work_reg.off_check && work_reg.off_time >= thresh)
        begin
            status = ST_LONG_OFF;
        end
    end

    assign finish  = (state_reg == S_DONE) && (!res_valid_reg || result.ready);
    assign ram_we  = finish && work_reg.in_range;
    assign rec_pop = rec_valid && ((state_reg == S_IDLE) || finish);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        work_next       = work_reg;
        valid_bits_next = valid_bits_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        res_ok_next     = res_ok_reg;
        res_on_next     = res_on_reg;
        res_off_next    = res_off_reg;
        res_derr_next   = res_derr_reg;

        case (state_reg)
            S_DIV:
            begin
                rem_next  = div_rem;
                quo_next  = div_quo;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    res_valid_next  = 1'b1;
                    res_index_next  = work_reg.det_index;
                    res_status_next = status;
                    res_ok_next     = n_ok;
                    res_on_next     = work_reg.long_on;
                    res_off_next    = work_reg.off_check && (work_reg.off_time >= thresh);
                    res_derr_next   = div_err;
                    if (ram_we)
                    begin
                        valid_bits_next[addr] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the next record straight away, also on the finishing cycle
        if (rec_pop)
        begin
            work_next  = rec;
            rem_next   = '0;
            quo_next   = regs.long_off_base;
            step_next  = '0;
            state_next = S_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            work_reg       <= '0;
            valid_bits_reg <= '0;
            res_valid_reg  <= 1'b0;
            res_index_reg  <= '0;
            res_status_reg <= ST_OK;
            res_ok_reg     <= 1'b0;
            res_on_reg     <= 1'b0;
            res_off_reg    <= 1'b0;
            res_derr_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            rem_reg        <= rem_next;
            quo_reg        <= quo_next;
            work_reg       <= work_next;
            valid_bits_reg <= valid_bits_next;
            res_valid_reg  <= res_valid_next;
            res_index_reg  <= res_index_next;
            res_status_reg <= res_status_next;
            res_ok_reg     <= res_ok_next;
            res_on_reg     <= res_on_next;
            res_off_reg    <= res_off_next;
            res_derr_reg   <= res_derr_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.result_index    = res_index_reg;
    assign result.new_status      = res_status_reg;
    assign result.notify_ok       = res_ok_reg;
    assign result.notify_long_on  = res_on_reg;
    assign result.notify_long_off = res_off_reg;
    assign result.divide_error    = res_derr_reg;

    `DFS_ASSERT(a_no_pop_in_div, clk, rst_n, !(rec_pop && state_reg == S_DIV))
    `DFS_ASSERT_IMPL(a_off_wins, clk, rst_n, res_valid_reg && res_off_reg, res_status_reg == ST_LONG_OFF)
    `DFS_ASSERT_IMPL(a_on_status, clk, rst_n, res_valid_reg && res_on_reg && !res_off_reg, res_status_reg == ST_LONG_ON)
    `DFS_ASSERT_IMPL(a_ok_status, clk, rst_n, res_valid_reg && res_ok_reg && !res_on_reg && !res_off_reg, res_status_reg == ST_OK)

endmodule
`default_nettype wire

// File: rtl/detector_fault_supervisor.sv
// Path: the front stage registers an accepted item, the queue holds it, and the
// back end runs the long-off divider (S_DIV), then the status update (S_DONE).
// The back end holds one item at a time; the front stage and queue take more.
// Reset: asynchronous, active low; restores register defaults, marks every
// detector status ok through per-entry valid bits, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module detector_fault_supervisor #(
    parameter int NUM_DETECTORS = dfs_pkg::NUM_DETECTORS_DEF,
    parameter int QUEUE_DEPTH   = dfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dfs_item_if.sink     item,
    dfs_result_if.source result,
    dfs_cfg_if.sink      cfg
);
    import dfs_pkg::*;

    dfs_cfg_t regs;
    dfs_rec_t front_rec;
    logic     front_valid;
    logic     front_ready;
    dfs_rec_t back_rec;
    logic     back_valid;
    logic     back_pop;

    dfs_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    dfs_front #(
        .NUM_DETECTORS (NUM_DETECTORS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .regs      (regs),
        .rec       (front_rec),
        .rec_valid (front_valid),
        .rec_ready (front_ready)
    );

    dfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_rec   (front_rec),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_rec    (back_rec),
        .pop_valid  (back_valid),
        .pop_ready  (back_pop)
    );

    dfs_back #(
        .NUM_DETECTORS (NUM_DETECTORS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .rec       (back_rec),
        .rec_valid (back_valid),
        .rec_pop   (back_pop),
        .result    (result)
    );

endmodule
`default_nettype wire
